// ===== rtl/core/llp_pkg.sv =====
// ----------------------------------------------------------------------------
// llp_pkg
// Shared types and constants of the LL(1) predictive parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package llp_pkg;

   localparam int SYM_W     = 5;
   localparam int RHS_SLOTS = 8;
   localparam int SYMS_W    = SYM_W * RHS_SLOTS;
   localparam int TBL_AW    = 8;
   localparam int TBL_DEPTH = 1 << TBL_AW;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_TOKEN = 2'd2;

   localparam logic [2:0] EV_EXPAND   = 3'd0;
   localparam logic [2:0] EV_MATCH    = 3'd1;
   localparam logic [2:0] EV_ACCEPT   = 3'd2;
   localparam logic [2:0] EV_NO_ENTRY = 3'd3;
   localparam logic [2:0] EV_MISMATCH = 3'd4;
   localparam logic [2:0] EV_OVERFLOW = 3'd5;
   localparam logic [2:0] EV_EXP_CAP  = 3'd6;

   localparam logic CSR_START_SYMBOL = 1'b0;
   localparam logic CSR_END_TERMINAL = 1'b1;

   typedef struct packed {
      logic [1:0]        kind;
      logic [3:0]        nonterminal;
      logic [3:0]        terminal;
      logic              entry_valid;
      logic [3:0]        rhs_length;
      logic [SYMS_W-1:0] rhs_symbols;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [3:0] nonterminal_out;
      logic [3:0] terminal_out;
      logic [3:0] production_length;
      logic [6:0] stack_depth;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]        len;
      logic [SYMS_W-1:0] syms;
   } tbl_entry_type;

   typedef struct packed {
      logic              en;
      logic [TBL_AW-1:0] addr;
      logic              valid;
      tbl_entry_type     entry;
   } tbl_wr_type;

   // Symbol k of a right side; slots past the packed field read as zero.
   function automatic logic [SYM_W-1:0] sym_at(logic [SYMS_W-1:0] syms, logic [3:0] k);
      logic [SYM_W-1:0] s;
      s = '0;
      for (int j = 0; j < RHS_SLOTS; j++) begin
         if (k == 4'(j)) begin
            s = syms[j*SYM_W +: SYM_W];
         end
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/llp_table.sv =====
// ----------------------------------------------------------------------------
// llp_table
// Parse table: valid bits in flops (cleared at reset), entry data in a RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module llp_table (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire llp_pkg::tbl_wr_type         wr,
   input  wire logic                        rd_en,
   input  wire logic [llp_pkg::TBL_AW-1:0]  rd_addr,
   output logic                             rd_hit,
   output llp_pkg::tbl_entry_type           rd_entry
);
   import llp_pkg::*;

   logic [TBL_DEPTH-1:0] valid_ff;
   tbl_entry_type        mem [TBL_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
      if (rd_en) begin
         rd_entry <= mem[rd_addr];
      end
   end

   assign rd_hit = valid_ff[rd_addr];

endmodule

`default_nettype wire

// ===== rtl/core/llp_stack.sv =====
// ----------------------------------------------------------------------------
// llp_stack
// Symbol stack RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module llp_stack #(
   parameter int DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [llp_pkg::SYM_W-1:0]  wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [llp_pkg::SYM_W-1:0]  rd_data
);
   import llp_pkg::*;

   logic [SYM_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/llp_ctrl.sv =====
// ----------------------------------------------------------------------------
// llp_ctrl
// Parse sequencer: fetches the stack top, looks up the table, pushes the
// right side one symbol a cycle and hands results to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module llp_ctrl #(
   parameter int NONTERMINALS   = 16,
   parameter int TERMINALS      = 16,
   parameter int MAX_RHS        = 8,
   parameter int STACK_DEPTH    = 64,
   parameter int MAX_EXPANSIONS = 31
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire llp_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output llp_pkg::rsp_type                      rsp_data,
   input  wire logic [3:0]                       start_symbol,
   input  wire logic [3:0]                       end_terminal,
   output llp_pkg::tbl_wr_type                   tbl_wr,
   output logic                                  tbl_rd_en,
   output logic [llp_pkg::TBL_AW-1:0]            tbl_rd_addr,
   input  wire logic                             tbl_hit,
   input  wire llp_pkg::tbl_entry_type           tbl_entry,
   output logic                                  stk_wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0]        stk_wr_addr,
   output logic [llp_pkg::SYM_W-1:0]             stk_wr_data,
   output logic [$clog2(STACK_DEPTH)-1:0]        stk_rd_addr,
   input  wire logic [llp_pkg::SYM_W-1:0]        stk_rd_data
);
   import llp_pkg::*;

   localparam int SIW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int EXW = $clog2(MAX_EXPANSIONS + 1);
   localparam logic [6:0]     NT_LIM  = 7'(NONTERMINALS);
   localparam logic [6:0]     T_LIM   = 7'(TERMINALS);
   localparam logic [3:0]     RHS_LIM = 4'(MAX_RHS);
   localparam logic [SPW:0]   SD_LIM  = (SPW + 1)'(STACK_DEPTH);
   localparam logic [EXW-1:0] EXP_LIM = EXW'(MAX_EXPANSIONS);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_START = 7'b0000010,
      S_FETCH = 7'b0000100,
      S_TOP   = 7'b0001000,
      S_ENTRY = 7'b0010000,
      S_PUSH  = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type      state_ff, state_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [EXW-1:0] exp_ff, exp_in;
   logic [3:0]     push_ff, push_in;
   logic [3:0]     tok_ff, tok_in;
   logic [3:0]     nt_ff, nt_in;
   logic           parsing_ff, parsing_in;
   rsp_type        pend_ff, pend_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   logic           accept;
   logic           out_free;
   logic [SPW-1:0] sp_dec;
   logic [SPW:0]   new_depth;
   logic [3:0]     len_sat;

   function automatic logic [6:0] depth7(logic [SPW-1:0] v);
      logic [SPW+6:0] w;
      w = {7'd0, v};
      return w[6:0];
   endfunction

   function automatic rsp_type mk(logic [2:0] ev, logic [3:0] nt, logic [3:0] t,
                                  logic [3:0] len, logic [SPW-1:0] d, logic lst);
      rsp_type r;
      r.event_res         = ev;
      r.nonterminal_out   = nt;
      r.terminal_out      = t;
      r.production_length = len;
      r.stack_depth       = depth7(d);
      r.last              = lst;
      return r;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign sp_dec    = sp_ff - SPW'(1);
   assign new_depth = {1'b0, sp_dec} + (SPW + 1)'(tbl_entry.len);
   assign len_sat   = (req_data.rhs_length > RHS_LIM) ? RHS_LIM : req_data.rhs_length;

   assign stk_rd_addr = sp_dec[SIW-1:0];
   assign tbl_rd_en   = (state_ff == S_TOP);
   assign tbl_rd_addr = {stk_rd_data[3:0], tok_ff};

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      exp_in       = exp_ff;
      push_in      = push_ff;
      tok_in       = tok_ff;
      nt_in        = nt_ff;
      parsing_in   = parsing_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;

      tbl_wr             = '0;
      tbl_wr.addr        = {req_data.nonterminal, req_data.terminal};
      tbl_wr.valid       = req_data.entry_valid;
      tbl_wr.entry.len   = len_sat;
      tbl_wr.entry.syms  = req_data.rhs_symbols;
      stk_wr_en          = 1'b0;
      stk_wr_addr        = '0;
      stk_wr_data        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  KIND_LOAD: begin
                     tbl_wr.en = ({3'd0, req_data.nonterminal} < NT_LIM) &&
                                 ({3'd0, req_data.terminal} < T_LIM);
                  end
                  KIND_START: begin
                     stk_wr_en   = 1'b1;
                     stk_wr_data = {1'b0, end_terminal};
                     state_in    = S_START;
                  end
                  KIND_TOKEN: begin
                     if (parsing_ff) begin
                        tok_in   = req_data.terminal;
                        exp_in   = '0;
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_START: begin
            stk_wr_en   = 1'b1;
            stk_wr_addr = SIW'(1);
            stk_wr_data = {1'b1, start_symbol};
            sp_in       = SPW'(2);
            parsing_in  = 1'b1;
            state_in    = S_IDLE;
         end
         S_FETCH: begin
            if (sp_ff == '0) begin
               pend_in    = mk(EV_MISMATCH, 4'd0, tok_ff, 4'd0, '0, 1'b1);
               parsing_in = 1'b0;
               state_in   = S_EMIT;
            end else begin
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            nt_in = stk_rd_data[3:0];
            if (!stk_rd_data[SYM_W-1]) begin
               if (stk_rd_data[3:0] == end_terminal && tok_ff == end_terminal) begin
                  pend_in    = mk(EV_ACCEPT, 4'd0, tok_ff, 4'd0, sp_ff, 1'b1);
                  parsing_in = 1'b0;
               end else if (stk_rd_data[3:0] == tok_ff) begin
                  sp_in   = sp_dec;
                  pend_in = mk(EV_MATCH, 4'd0, tok_ff, 4'd0, sp_dec, 1'b1);
               end else begin
                  pend_in    = mk(EV_MISMATCH, 4'd0, tok_ff, 4'd0, sp_ff, 1'b1);
                  parsing_in = 1'b0;
               end
               state_in = S_EMIT;
            end else if (({3'd0, stk_rd_data[3:0]} >= NT_LIM) ||
                         ({3'd0, tok_ff} >= T_LIM) || !tbl_hit) begin
               pend_in    = mk(EV_NO_ENTRY, stk_rd_data[3:0], tok_ff, 4'd0, sp_ff, 1'b1);
               parsing_in = 1'b0;
               state_in   = S_EMIT;
            end else begin
               state_in = S_ENTRY;
            end
         end
         S_ENTRY: begin
            if (exp_ff == EXP_LIM) begin
               pend_in    = mk(EV_EXP_CAP, nt_ff, tok_ff, tbl_entry.len, sp_ff, 1'b1);
               parsing_in = 1'b0;
               state_in   = S_EMIT;
            end else if (new_depth > SD_LIM) begin
               pend_in    = mk(EV_OVERFLOW, nt_ff, tok_ff, tbl_entry.len, sp_ff, 1'b1);
               parsing_in = 1'b0;
               state_in   = S_EMIT;
            end else begin
               sp_in   = sp_dec;
               exp_in  = exp_ff + EXW'(1);
               push_in = tbl_entry.len;
               if (tbl_entry.len == 4'd0) begin
                  pend_in  = mk(EV_EXPAND, nt_ff, tok_ff, 4'd0, sp_dec, 1'b0);
                  state_in = S_EMIT;
               end else begin
                  state_in = S_PUSH;
               end
            end
         end
         S_PUSH: begin
            // last symbol of the right side goes in first, so the first ends on top
            stk_wr_en   = 1'b1;
            stk_wr_addr = sp_ff[SIW-1:0];
            stk_wr_data = sym_at(tbl_entry.syms, push_ff - 4'd1);
            sp_in       = sp_ff + SPW'(1);
            push_in     = push_ff - 4'd1;
            if (push_ff == 4'd1) begin
               pend_in  = mk(EV_EXPAND, nt_ff, tok_ff, tbl_entry.len,
                             sp_ff + SPW'(1), 1'b0);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = pend_ff.last ? S_IDLE : S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         parsing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         parsing_ff   <= parsing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff      <= exp_in;
      push_ff     <= push_in;
      tok_ff      <= tok_in;
      nt_ff       <= nt_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ll1_predictive_parser.sv =====
// ----------------------------------------------------------------------------
// ll1_predictive_parser
// Table-driven LL(1) predictive parser with loadable parse table.
// ----------------------------------------------------------------------------
//  channel | ports                            | direction
//  --------+----------------------------------+------------------------------
//  req     | req_valid req_stall req_data     | load / start / token in
//  rsp     | rsp_valid rsp_stall rsp_data     | expand / match / accept / error
//  csr     | csr_we csr_index csr_wdata       | start symbol, end terminal
//
//  Load requests and tokens outside a parse are handled in idle. A token
//  fetches the stack top, reads the table and pushes the right side one
//  symbol per cycle; each result goes through the output register. The
//  parse table's valid bits clear at reset. A stalled result holds the
//  sequencer only when the next one is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ll1_predictive_parser #(
   parameter int NONTERMINALS   = 16,
   parameter int TERMINALS      = 16,
   parameter int MAX_RHS        = 8,
   parameter int STACK_DEPTH    = 64,
   parameter int MAX_EXPANSIONS = 31
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire llp_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output llp_pkg::rsp_type       rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [3:0]        csr_wdata
);
   import llp_pkg::*;

   localparam int SIW = $clog2(STACK_DEPTH);

   logic [3:0]       start_symbol_ff;
   logic [3:0]       end_terminal_ff;

   tbl_wr_type       tbl_wr;
   logic             tbl_rd_en;
   logic [TBL_AW-1:0] tbl_rd_addr;
   logic             tbl_hit;
   tbl_entry_type    tbl_entry;
   logic             stk_wr_en;
   logic [SIW-1:0]   stk_wr_addr;
   logic [SYM_W-1:0] stk_wr_data;
   logic [SIW-1:0]   stk_rd_addr;
   logic [SYM_W-1:0] stk_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_symbol_ff <= 4'd0;
         end_terminal_ff <= 4'd15;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_SYMBOL: start_symbol_ff <= csr_wdata;
            CSR_END_TERMINAL: end_terminal_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   llp_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd_en    (tbl_rd_en),
      .rd_addr  (tbl_rd_addr),
      .rd_hit   (tbl_hit),
      .rd_entry (tbl_entry)
   );

   llp_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   llp_ctrl #(
      .NONTERMINALS   (NONTERMINALS),
      .TERMINALS      (TERMINALS),
      .MAX_RHS        (MAX_RHS),
      .STACK_DEPTH    (STACK_DEPTH),
      .MAX_EXPANSIONS (MAX_EXPANSIONS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .start_symbol (start_symbol_ff),
      .end_terminal (end_terminal_ff),
      .tbl_wr       (tbl_wr),
      .tbl_rd_en    (tbl_rd_en),
      .tbl_rd_addr  (tbl_rd_addr),
      .tbl_hit      (tbl_hit),
      .tbl_entry    (tbl_entry),
      .stk_wr_en    (stk_wr_en),
      .stk_wr_addr  (stk_wr_addr),
      .stk_wr_data  (stk_wr_data),
      .stk_rd_addr  (stk_rd_addr),
      .stk_rd_data  (stk_rd_data)
   );

endmodule

`default_nettype wire
